/* src/atsu_pkg.sv */
`timescale 1ns / 1ps
package atsu_pkg;

  localparam int LANES_DEF  = 8;
  localparam int LANE_W     = 3;
  localparam int DATA_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int DIV_BITS   = 32;
  localparam int DIV_CNT_W  = $clog2(DIV_BITS);

  localparam logic [DATA_W-1:0] ENERGY_RST   = 32'hFFFF_0000;
  localparam logic [DATA_W-1:0] BASE_MIN_RST = 32'd65536;
  localparam logic [DATA_W-1:0] BASE_MAX_RST = 32'd655360;
  localparam logic [DATA_W-1:0] TAU_RST      = 32'd65536;
  localparam logic [DATA_W-1:0] GROWTH_RST   = 32'd655;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAU      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GROWTH   = 2'd3;

  typedef struct packed {
    logic        [LANE_W-1:0] lane;
    logic signed [DATA_W-1:0] energy;
  } in_item_t;

  typedef struct packed {
    logic [LANE_W-1:0] lane_out;
    logic [DATA_W-1:0] time_scale;
    logic [DATA_W-1:0] time_scale_ceiling;
    logic              reset_taken;
    logic              held;
  } out_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] base_min;
    logic [DATA_W-1:0] base_max;
    logic [DATA_W-1:0] tau_factor;
    logic [DATA_W-1:0] growth_factor;
  } cfg_t;

  // One lane's stored state
  typedef struct packed {
    logic [DATA_W-1:0] energy;
    logic [DATA_W-1:0] time_scale;
    logic [DATA_W-1:0] ceiling;
  } entry_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_READ,
    OP_LOAD,
    OP_MUL_P,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_SUM,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_CEIL,
    OP_GROW,
    OP_COMMIT
  } op_t;

  typedef enum logic [1:0] {
    KIND_OOB,
    KIND_HELD,
    KIND_RESET,
    KIND_COMPUTE
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_MUL_P,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_DIV_INIT,
    ST_DIV,
    ST_CEIL,
    ST_GROW,
    ST_FINISH
  } state_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  over;
    logic  out_free;
  } status_t;

endpackage

/* src/atsu_ram.sv */
`timescale 1ns / 1ps
module atsu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/atsu_ctrl.sv */
`timescale 1ns / 1ps
module atsu_ctrl
  import atsu_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t sts_i,
  output cmd_t    cmd_o
);

  state_t                 state_r, state_nxt;
  logic [DIV_CNT_W-1:0]   cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd_o.op  = OP_NONE;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd_o.op  = OP_CAPTURE;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.op  = OP_READ;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.op  = OP_LOAD;
        state_nxt = ST_MUL_P;
      end
      ST_MUL_P: begin
        cmd_o.op  = OP_MUL_P;
        state_nxt = (sts_i.kind == KIND_COMPUTE) ? ST_MUL_LO : ST_FINISH;
      end
      ST_MUL_LO: begin
        cmd_o.op  = OP_MUL_LO;
        state_nxt = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd_o.op  = OP_MUL_HI;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.op  = OP_SUM;
        state_nxt = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd_o.op  = OP_DIV_INIT;
        cnt_nxt   = '0;
        state_nxt = sts_i.over ? ST_CEIL : ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        cnt_nxt  = cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DIV_BITS - 1)) begin
          state_nxt = ST_CEIL;
        end
      end
      ST_CEIL: begin
        cmd_o.op  = OP_CEIL;
        state_nxt = ST_GROW;
      end
      ST_GROW: begin
        cmd_o.op  = OP_GROW;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.op  = OP_COMMIT;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* src/atsu_dp.sv */
`timescale 1ns / 1ps
module atsu_dp
  import atsu_pkg::*;
#(
  parameter int LANES = LANES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg_i,
  input  in_item_t  in_payload,
  input  cmd_t      cmd_i,
  output status_t   sts_o,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t out_payload
);

  localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;

  logic        [LANE_W-1:0] lane_r;
  logic signed [DATA_W-1:0] enew_r;
  logic signed [DATA_W-1:0] eold_r;
  logic        [DATA_W-1:0] ts_old_r;
  logic        [DATA_W-1:0] ceil_old_r;
  logic        [DATA_W-1:0] diff_r;
  logic        [63:0]       p_r;
  logic        [62:0]       prod_lo_r;
  logic        [62:0]       prod_hi_r;
  logic        [78:0]       num_r;
  logic        [DATA_W-1:0] rem_r;
  logic        [DATA_W-1:0] quo_r;
  logic                     ge_r;
  logic        [63:0]       grow_prod_r;
  logic        [DATA_W-1:0] res_ts_r;
  logic        [DATA_W-1:0] res_ceil_r;
  logic        [LANES-1:0]  vld_r;
  logic                     out_valid_r;
  out_item_t                out_payload_r;

  logic [IDX_W-1:0]   idx;
  entry_t             rd_entry;
  entry_t             wr_entry;
  logic               wr_en;
  kind_t              kind;
  logic [30:0]        e0;
  logic [94:0]        num_full;
  logic [DATA_W-1:0]  rem_sh;
  logic [48:0]        grown;
  logic               step_bit;

  assign idx = IDX_W'(lane_r);
  assign e0  = eold_r[30:0];

  atsu_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (LANES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (idx),
    .wdata (wr_entry),
    .re    (cmd_i.op == OP_READ),
    .raddr (idx),
    .rdata (rd_entry)
  );

  always_comb begin
    if (int'(lane_r) >= LANES) begin
      kind = KIND_OOB;
    end else if (enew_r == eold_r) begin
      kind = KIND_HELD;
    end else if (enew_r > eold_r || eold_r <= 32'sd0 || enew_r <= 32'sd0) begin
      kind = KIND_RESET;
    end else begin
      kind = KIND_COMPUTE;
    end
  end

  assign num_full = {prod_hi_r, 32'd0} + {32'd0, prod_lo_r};
  assign rem_sh   = {rem_r[30:0], quo_r[31]};
  assign step_bit = (rem_sh >= diff_r);
  assign grown    = {17'd0, ceil_old_r} + {1'b0, grow_prod_r[63:16]};

  assign sts_o.kind     = kind;
  assign sts_o.over     = (num_r[78:32] >= {15'd0, diff_r});
  assign sts_o.out_free = !out_valid_r || !out_stall;

  assign wr_en    = (cmd_i.op == OP_COMMIT) && (kind != KIND_OOB);
  assign wr_entry = '{energy: enew_r, time_scale: res_ts_r, ceiling: res_ceil_r};

  always_ff @(posedge clk) begin
    case (cmd_i.op)
      OP_CAPTURE: begin
        lane_r <= in_payload.lane;
        enew_r <= in_payload.energy;
      end
      OP_LOAD: begin
        if (vld_r[idx]) begin
          eold_r     <= rd_entry.energy;
          ts_old_r   <= rd_entry.time_scale;
          ceil_old_r <= rd_entry.ceiling;
        end else begin
          eold_r     <= ENERGY_RST;
          ts_old_r   <= BASE_MIN_RST;
          ceil_old_r <= BASE_MAX_RST;
        end
      end
      OP_MUL_P: begin
        p_r    <= 64'(cfg_i.tau_factor) * 64'(ts_old_r);
        diff_r <= $unsigned(eold_r - enew_r);
        // Results for the paths that skip the arithmetic
        if (kind == KIND_RESET) begin
          res_ts_r   <= cfg_i.base_min;
          res_ceil_r <= cfg_i.base_max;
        end else begin
          res_ts_r   <= ts_old_r;
          res_ceil_r <= ceil_old_r;
        end
      end
      OP_MUL_LO: begin
        prod_lo_r <= 63'(p_r[31:0]) * 63'(e0);
      end
      OP_MUL_HI: begin
        prod_hi_r <= 63'(p_r[63:32]) * 63'(e0);
      end
      OP_SUM: begin
        num_r <= num_full[94:16];
      end
      OP_DIV_INIT: begin
        rem_r  <= num_r[63:32];
        quo_r  <= sts_o.over ? '1 : num_r[31:0];
      end
      OP_DIV_STEP: begin
        rem_r <= step_bit ? (rem_sh - diff_r) : rem_sh;
        quo_r <= {quo_r[30:0], step_bit};
      end
      OP_CEIL: begin
        ge_r        <= (quo_r >= ceil_old_r);
        grow_prod_r <= 64'(ceil_old_r) * 64'(cfg_i.growth_factor);
      end
      OP_GROW: begin
        if (ge_r) begin
          res_ts_r   <= ceil_old_r;
          res_ceil_r <= (grown[48:32] != 17'd0) ? '1 : grown[31:0];
        end else begin
          res_ts_r   <= quo_r;
          res_ceil_r <= ceil_old_r;
        end
      end
      OP_COMMIT: begin
        out_payload_r.lane_out <= lane_r;
        if (kind == KIND_OOB) begin
          out_payload_r.time_scale         <= '0;
          out_payload_r.time_scale_ceiling <= '0;
        end else begin
          out_payload_r.time_scale         <= res_ts_r;
          out_payload_r.time_scale_ceiling <= res_ceil_r;
        end
        out_payload_r.reset_taken <= (kind == KIND_RESET);
        out_payload_r.held        <= (kind == KIND_HELD);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[idx] <= 1'b1;
      end
      if (cmd_i.op == OP_COMMIT) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;

endmodule

/* src/adaptive_time_scale_update_top.sv */
`timescale 1ns / 1ps
// A computed quotient runs the 32-step serial divider, a saturating quotient skips it,
// and a lane that holds, resets or is out of range skips all of the arithmetic.
// A new transaction is accepted only after the last one is committed, which waits on out_stall.
// Reset (rst_n, synchronous, active low) loads the register defaults and marks every
// lane entry invalid, so all lanes read as energy -1.0, base_min and base_max reset values.
module adaptive_time_scale_update_top
  import atsu_pkg::*;
#(
  parameter int LANES = LANES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_payload,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_payload,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata
);

  cfg_t    cfg_r;
  cmd_t    cmd;
  status_t sts;

  // Configuration registers; the user must write them only while the block is idle,
  // which it does not enforce; the datapath reads them directly without a shadow copy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_min      <= BASE_MIN_RST;
      cfg_r.base_max      <= BASE_MAX_RST;
      cfg_r.tau_factor    <= TAU_RST;
      cfg_r.growth_factor <= GROWTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_MIN: cfg_r.base_min      <= cfg_wdata;
        REG_BASE_MAX: cfg_r.base_max      <= cfg_wdata;
        REG_TAU:      cfg_r.tau_factor    <= cfg_wdata;
        REG_GROWTH:   cfg_r.growth_factor <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Sequence each transaction: capture, lane state read, classify, then the
  // multiply / divide / clamp steps, and finally commit to the lane store
  // and the output register.
  atsu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  // Lane store, arithmetic and output register. The output register frees
  // the controller to accept the next transaction while a result waits.
  atsu_dp #(
    .LANES (LANES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_i       (cfg_r),
    .in_payload  (in_payload),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_payload (out_payload)
  );

endmodule
